// ===== rtl/pps_pkg.sv =====
// Package for the preemptive priority scheduler.
// Holds field widths, command and status codes, and the packed slot record.
// No dependencies; the top level refers to it by scoped names.
package pps_pkg;

    // Field widths fixed by the item format
    localparam int ID_W    = 8;
    localparam int TIME_W  = 32;
    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int DONE_W  = 5;

    // Table depth default for the top level
    localparam int DEFAULT_TABLE_DEPTH = 16;

    // Saturation limits
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [DONE_W-1:0] DONE_MAX = {DONE_W{1'b1}};

    // Input command codes
    typedef enum logic {
        CMD_ADMIT = 1'b0,
        CMD_TICK  = 1'b1
    } t_command;

    // Result status codes
    typedef enum logic [1:0] {
        ST_ADMITTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_RAN      = 2'd2,
        ST_IDLE     = 2'd3
    } t_status;

    // Static part of a table entry, written once on admit
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [TIME_W-1:0]  arrival;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } t_slot_info;

    localparam int INFO_W = $bits(t_slot_info);

endpackage

// ===== rtl/pps_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the scheduler's process table. No package dependencies.
module pps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/preemptive_priority_scheduler_unit.sv =====
// Preemptive priority scheduler, top level.
// Depends on pps_pkg (types, widths, codes) and pps_ram (process table storage).
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one command item: admit a
//   process (id, arrival, burst, priority) or tick one time unit. Output channel
//   (o_out_valid / i_out_ready) returns exactly one result item per command.
//   An admit goes from accept straight to POST, which loads the result. A tick
//   scans the N admitted entries in the SCAN state: the table RAM is read one entry
//   per cycle and a single comparator keeps the most urgent ready entry (lowest
//   priority number, lowest slot on ties); then the UPD state advances time. When
//   the served process completes, turnaround, waiting and total updates are done
//   in turn in the TURN, WAIT and SUM states before POST. A tick on an empty
//   table skips the scan and goes straight to UPD.
//   One item is in flight at a time; o_in_ready is high only when idle.
//   The result sits in an output register; if the receiver stalls, the block
//   holds the result and finishes the next item only once it is taken.
//   Reset (synchronous, active low) empties the table, zeroes time, totals and
//   counts. Table RAM contents are not cleared: the fill count marks which slots
//   hold entries, so no clearing pass is needed.
module preemptive_priority_scheduler_unit #(
    parameter int TABLE_DEPTH = pps_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Input item channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_command,
    input  logic [pps_pkg::ID_W-1:0]     i_proc_id,
    input  logic [pps_pkg::TIME_W-1:0]   i_arrival,
    input  logic [pps_pkg::BURST_W-1:0]  i_burst,
    input  logic [pps_pkg::PRIO_W-1:0]   i_prio,
    // Result item channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [1:0]                   o_status,
    output logic [pps_pkg::ID_W-1:0]     o_run_id,
    output logic [pps_pkg::TIME_W-1:0]   o_time_now,
    output logic                         o_finished,
    output logic [pps_pkg::TIME_W-1:0]   o_turnaround,
    output logic [pps_pkg::TIME_W-1:0]   o_waiting,
    output logic [pps_pkg::TIME_W-1:0]   o_sum_waiting,
    output logic [pps_pkg::TIME_W-1:0]   o_sum_turnaround,
    output logic [pps_pkg::DONE_W-1:0]   o_done_count,
    output logic                         o_all_done
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int TW    = pps_pkg::TIME_W;

    localparam logic [pps_pkg::BURST_W-1:0] BURST_ONE = pps_pkg::BURST_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_UPD,
        S_TURN,
        S_WAIT,
        S_SUM,
        S_POST
    } t_state;

    // Sequencer and table bookkeeping
    t_state                     r_state, n_state;
    logic [CNT_W-1:0]           r_slot_count, n_slot_count;
    logic [CNT_W-1:0]           r_active, n_active;
    logic [TW-1:0]              r_time, n_time;
    logic [TW-1:0]              r_sum_wait, n_sum_wait;
    logic [TW-1:0]              r_sum_turn, n_sum_turn;
    logic [pps_pkg::DONE_W-1:0] r_done_cnt, n_done_cnt;

    // Scan pointer and read pipeline
    logic [IDX_W-1:0]           r_addr, n_addr;
    logic                       r_issue, n_issue;
    logic                       r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]           r_rd_idx, n_rd_idx;

    // Best candidate so far
    logic                        r_found, n_found;
    logic [IDX_W-1:0]            r_best_idx, n_best_idx;
    logic [pps_pkg::PRIO_W-1:0]  r_best_prio, n_best_prio;
    logic [pps_pkg::ID_W-1:0]    r_best_id, n_best_id;
    logic [TW-1:0]               r_best_arr, n_best_arr;
    logic [pps_pkg::BURST_W-1:0] r_best_burst, n_best_burst;
    logic [pps_pkg::BURST_W-1:0] r_best_rem, n_best_rem;

    // Working result of the current item
    pps_pkg::t_status           r_status, n_status;
    logic [pps_pkg::ID_W-1:0]   r_run_id, n_run_id;
    logic                       r_fin, n_fin;
    logic [TW-1:0]              r_turn, n_turn;
    logic [TW-1:0]              r_wait, n_wait;

    // Output register
    logic                       r_out_valid, n_out_valid;
    pps_pkg::t_status           r_o_status, n_o_status;
    logic [pps_pkg::ID_W-1:0]   r_o_run_id, n_o_run_id;
    logic [TW-1:0]              r_o_time, n_o_time;
    logic                       r_o_fin, n_o_fin;
    logic [TW-1:0]              r_o_turn, n_o_turn;
    logic [TW-1:0]              r_o_wait, n_o_wait;
    logic [TW-1:0]              r_o_sum_wait, n_o_sum_wait;
    logic [TW-1:0]              r_o_sum_turn, n_o_sum_turn;
    logic [pps_pkg::DONE_W-1:0] r_o_done, n_o_done;
    logic                       r_o_all_done, n_o_all_done;

    // RAM ports
    logic                        info_wr_en;
    pps_pkg::t_slot_info         info_wr_data;
    pps_pkg::t_slot_info         info_rd;
    logic                        rem_wr_en;
    logic [IDX_W-1:0]            rem_wr_addr;
    logic [pps_pkg::BURST_W-1:0] rem_wr_data;
    logic [pps_pkg::BURST_W-1:0] rem_rd;
    logic                        rd_en;

    logic in_fire;
    logic out_fire;
    logic table_full;

    assign in_fire    = i_in_valid && o_in_ready;
    assign out_fire   = r_out_valid && i_out_ready;
    assign table_full = (r_slot_count >= CNT_W'(TABLE_DEPTH));

    // Static entry fields: id, arrival, burst, priority
    assign info_wr_en   = in_fire && (i_command == pps_pkg::CMD_ADMIT) && !table_full;
    assign info_wr_data = '{id: i_proc_id, arrival: i_arrival, burst: i_burst, prio: i_prio};
    assign rd_en        = (r_state == S_SCAN) && r_issue;

    pps_ram #(
        .WIDTH (pps_pkg::INFO_W),
        .DEPTH (TABLE_DEPTH)
    ) u_info_ram (
        .i_clk     (i_clk),
        .i_wr_en   (info_wr_en),
        .i_wr_addr (r_slot_count[IDX_W-1:0]),
        .i_wr_data (info_wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (info_rd)
    );

    // Remaining service: written on admit and when an entry is served
    always_comb begin
        rem_wr_en   = 1'b0;
        rem_wr_addr = r_slot_count[IDX_W-1:0];
        rem_wr_data = i_burst;
        if (info_wr_en) begin
            rem_wr_en = 1'b1;
        end else if (r_state == S_UPD && r_found) begin
            rem_wr_en   = 1'b1;
            rem_wr_addr = r_best_idx;
            rem_wr_data = r_best_rem - 1'b1;
        end
    end

    pps_ram #(
        .WIDTH (pps_pkg::BURST_W),
        .DEPTH (TABLE_DEPTH)
    ) u_rem_ram (
        .i_clk     (i_clk),
        .i_wr_en   (rem_wr_en),
        .i_wr_addr (rem_wr_addr),
        .i_wr_data (rem_wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (rem_rd)
    );

    // Next-state logic for the sequencer
    always_comb begin
        logic          better;
        logic [TW:0]   turn_sum;
        logic [TW:0]   wait_sum;

        n_state      = r_state;
        n_slot_count = r_slot_count;
        n_active     = r_active;
        n_time       = r_time;
        n_sum_wait   = r_sum_wait;
        n_sum_turn   = r_sum_turn;
        n_done_cnt   = r_done_cnt;
        n_addr       = r_addr;
        n_issue      = r_issue;
        n_rd_vld     = r_rd_vld;
        n_rd_idx     = r_rd_idx;
        n_found      = r_found;
        n_best_idx   = r_best_idx;
        n_best_prio  = r_best_prio;
        n_best_id    = r_best_id;
        n_best_arr   = r_best_arr;
        n_best_burst = r_best_burst;
        n_best_rem   = r_best_rem;
        n_status     = r_status;
        n_run_id     = r_run_id;
        n_fin        = r_fin;
        n_turn       = r_turn;
        n_wait       = r_wait;
        n_out_valid  = r_out_valid;
        n_o_status   = r_o_status;
        n_o_run_id   = r_o_run_id;
        n_o_time     = r_o_time;
        n_o_fin      = r_o_fin;
        n_o_turn     = r_o_turn;
        n_o_wait     = r_o_wait;
        n_o_sum_wait = r_o_sum_wait;
        n_o_sum_turn = r_o_sum_turn;
        n_o_done     = r_o_done;
        n_o_all_done = r_o_all_done;

        // Entry read last cycle is ready, arrived and more urgent than the best
        better = r_rd_vld && (rem_rd != '0) && (info_rd.arrival <= r_time) &&
                 (!r_found || (info_rd.prio < r_best_prio));
        turn_sum = {1'b0, r_sum_turn} + {1'b0, r_turn};
        wait_sum = {1'b0, r_sum_wait} + {1'b0, r_wait};

        // Drop the output item once taken
        if (out_fire) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_run_id = '0;
                    n_fin    = 1'b0;
                    n_turn   = '0;
                    n_wait   = '0;
                    n_found  = 1'b0;
                    if (i_command == pps_pkg::CMD_ADMIT) begin
                        if (table_full) begin
                            n_status = pps_pkg::ST_FULL;
                        end else begin
                            n_status     = pps_pkg::ST_ADMITTED;
                            n_slot_count = r_slot_count + 1'b1;
                            if (i_burst != '0) begin
                                n_active = r_active + 1'b1;
                            end
                        end
                        n_state = S_POST;
                    end else if (r_slot_count == '0) begin
                        n_state = S_UPD;
                    end else begin
                        n_addr   = '0;
                        n_issue  = 1'b1;
                        n_rd_vld = 1'b0;
                        n_state  = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // Keep the most urgent candidate; strict compare keeps lowest slot
                if (better) begin
                    n_found      = 1'b1;
                    n_best_idx   = r_rd_idx;
                    n_best_prio  = info_rd.prio;
                    n_best_id    = info_rd.id;
                    n_best_arr   = info_rd.arrival;
                    n_best_burst = info_rd.burst;
                    n_best_rem   = rem_rd;
                end
                // Advance the read pointer over the filled slots
                if (r_issue) begin
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_addr;
                    if (r_addr == IDX_W'(r_slot_count - 1'b1)) begin
                        n_issue = 1'b0;
                    end else begin
                        n_addr = r_addr + 1'b1;
                    end
                end else begin
                    n_rd_vld = 1'b0;
                    n_state  = S_UPD;
                end
            end
            S_UPD: begin
                if (r_time != pps_pkg::TIME_MAX) begin
                    n_time = r_time + 1'b1;
                end
                if (r_found) begin
                    n_status = pps_pkg::ST_RAN;
                    n_run_id = r_best_id;
                    if (r_best_rem == BURST_ONE) begin
                        n_fin   = 1'b1;
                        n_state = S_TURN;
                    end else begin
                        n_state = S_POST;
                    end
                end else begin
                    n_status = pps_pkg::ST_IDLE;
                    n_state  = S_POST;
                end
            end
            S_TURN: begin
                n_turn  = r_time - r_best_arr;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (r_turn >= TW'(r_best_burst)) begin
                    n_wait = r_turn - TW'(r_best_burst);
                end else begin
                    n_wait = '0;
                end
                n_state = S_SUM;
            end
            S_SUM: begin
                n_sum_turn = turn_sum[TW] ? pps_pkg::TIME_MAX : turn_sum[TW-1:0];
                n_sum_wait = wait_sum[TW] ? pps_pkg::TIME_MAX : wait_sum[TW-1:0];
                if (r_done_cnt != pps_pkg::DONE_MAX) begin
                    n_done_cnt = r_done_cnt + 1'b1;
                end
                n_active = r_active - 1'b1;
                n_state  = S_POST;
            end
            S_POST: begin
                // Load the output register once it is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_o_status   = r_status;
                    n_o_run_id   = r_run_id;
                    n_o_time     = r_time;
                    n_o_fin      = r_fin;
                    n_o_turn     = r_turn;
                    n_o_wait     = r_wait;
                    n_o_sum_wait = r_sum_wait;
                    n_o_sum_turn = r_sum_turn;
                    n_o_done     = r_done_cnt;
                    n_o_all_done = (r_active == '0);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_slot_count <= '0;
            r_active     <= '0;
            r_time       <= '0;
            r_sum_wait   <= '0;
            r_sum_turn   <= '0;
            r_done_cnt   <= '0;
            r_issue      <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_found      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_slot_count <= n_slot_count;
            r_active     <= n_active;
            r_time       <= n_time;
            r_sum_wait   <= n_sum_wait;
            r_sum_turn   <= n_sum_turn;
            r_done_cnt   <= n_done_cnt;
            r_issue      <= n_issue;
            r_rd_vld     <= n_rd_vld;
            r_found      <= n_found;
            r_out_valid  <= n_out_valid;
        end
        r_addr       <= n_addr;
        r_rd_idx     <= n_rd_idx;
        r_best_idx   <= n_best_idx;
        r_best_prio  <= n_best_prio;
        r_best_id    <= n_best_id;
        r_best_arr   <= n_best_arr;
        r_best_burst <= n_best_burst;
        r_best_rem   <= n_best_rem;
        r_status     <= n_status;
        r_run_id     <= n_run_id;
        r_fin        <= n_fin;
        r_turn       <= n_turn;
        r_wait       <= n_wait;
        r_o_status   <= n_o_status;
        r_o_run_id   <= n_o_run_id;
        r_o_time     <= n_o_time;
        r_o_fin      <= n_o_fin;
        r_o_turn     <= n_o_turn;
        r_o_wait     <= n_o_wait;
        r_o_sum_wait <= n_o_sum_wait;
        r_o_sum_turn <= n_o_sum_turn;
        r_o_done     <= n_o_done;
        r_o_all_done <= n_o_all_done;
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_o_status;
    assign o_run_id         = r_o_run_id;
    assign o_time_now       = r_o_time;
    assign o_finished       = r_o_fin;
    assign o_turnaround     = r_o_turn;
    assign o_waiting        = r_o_wait;
    assign o_sum_waiting    = r_o_sum_wait;
    assign o_sum_turnaround = r_o_sum_turn;
    assign o_done_count     = r_o_done;
    assign o_all_done       = r_o_all_done;

    // Entries with work left never outnumber filled slots
    a_active_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active <= r_slot_count)
        else $error("active entry count exceeds filled slot count");

    // Fill count never passes the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot_count <= CNT_W'(TABLE_DEPTH))
        else $error("slot count beyond table depth");

    // A scan only runs over a non-empty table
    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_slot_count != '0)
        else $error("scan started on an empty table");

    // A completion is only reported for a process that ran
    a_fin_ran: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_o_fin |-> r_o_status == pps_pkg::ST_RAN)
        else $error("finished flag without a served process");

    // An admit leaves time untouched
    a_admit_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_command == pps_pkg::CMD_ADMIT |=> $stable(r_time))
        else $error("time moved on an admit");

endmodule
